// ===== design/min_asg_pkg.sv =====
// ----------------------------------------------------------------------------
// min_asg_pkg
// Shared widths, constants and types for the min-cost assignment solver.
// ----------------------------------------------------------------------------
package min_asg_pkg;

    localparam int SIZE_W  = 5;
    localparam int COST_W  = 14;
    localparam int TOTAL_W = 18;
    localparam int POT_W   = 32;

    // internal slack infinity, far above any reduced cost
    localparam logic signed [POT_W-1:0] BIG_SLACK = 32'sh4000_0000;

    typedef struct packed {
        logic [SIZE_W-1:0] n;
    } job_t;

    typedef struct packed {
        logic q_empty;
        logic solving;
    } load_gate_t;

endpackage

// ===== design/min_asg_ram.sv =====
// ----------------------------------------------------------------------------
// min_asg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module min_asg_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/min_asg_queue.sv =====
// ----------------------------------------------------------------------------
// min_asg_queue
// Two-entry job queue between the load front and the solver.
// ----------------------------------------------------------------------------
module min_asg_queue
    import min_asg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head_job,
    output logic empty
);

    job_t       slot_reg [0:1];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign do_push  = push && (cnt_reg != 2'd2);
    assign do_pop   = pop && (cnt_reg != 2'd0);
    assign empty    = (cnt_reg == 2'd0);
    assign head_job = slot_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wp_reg] <= push_job;
        end
    end

endmodule

// ===== design/min_asg_front.sv =====
// ----------------------------------------------------------------------------
// min_asg_front
// Load front: writes each word into the cost store while it has room, queues a job on last.
// ----------------------------------------------------------------------------
module min_asg_front
    import min_asg_pkg::*;
#(
    parameter int MAX_SIZE = 16,
    parameter int AW       = 8,
    parameter int LCW      = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cost_valid,
    output logic              cost_ready,
    input  logic [SIZE_W-1:0] size,
    input  logic [COST_W-1:0] cost,
    input  logic              last,
    input  load_gate_t        gate,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [COST_W-1:0] wr_data,
    output logic              push,
    output job_t              push_job
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;

    logic [LCW-1:0] load_count_reg;
    logic [LCW-1:0] load_count_next;
    logic           accept;
    logic           room;

    assign cost_ready = gate.q_empty && !gate.solving;
    assign accept     = cost_valid && cost_ready;
    assign room       = (load_count_reg < LCW'(DEPTH));
    assign wr_en      = accept && room;
    assign wr_addr    = load_count_reg[AW-1:0];
    assign wr_data    = cost;
    assign push       = accept && last;

    always_comb
    begin
        if (32'(size) > MAX_SIZE)
        begin
            push_job.n = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            push_job.n = size;
        end
    end

    always_comb
    begin
        load_count_next = load_count_reg;
        if (accept)
        begin
            if (last)
            begin
                load_count_next = '0;
            end
            else if (room)
            begin
                load_count_next = load_count_reg + LCW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
        end
        else
        begin
            load_count_reg <= load_count_next;
        end
    end

endmodule

// ===== design/min_asg_solver.sv =====
// ----------------------------------------------------------------------------
// min_asg_solver
// Back end: potential-based Hungarian solve over the cost store, then sum.
// ----------------------------------------------------------------------------
module min_asg_solver
    import min_asg_pkg::*;
#(
    parameter int MAX_SIZE    = 16,
    parameter int UNREACHABLE = 9999,
    parameter int AW          = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  job_t               job,
    output logic               pop,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  logic [COST_W-1:0]  rd_data,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [TOTAL_W-1:0] match_total,
    output logic               infeasible,
    output logic               solving
);

    localparam int CW = $clog2(MAX_SIZE + 2);
    localparam int PW = 2 * CW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PHASE  = 4'd1;
    localparam logic [3:0] S_STEP   = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_SCANRD = 4'd4;
    localparam logic [3:0] S_SCANEV = 4'd5;
    localparam logic [3:0] S_UPD    = 4'd6;
    localparam logic [3:0] S_CHECK  = 4'd7;
    localparam logic [3:0] S_AUG    = 4'd8;
    localparam logic [3:0] S_SUMMUL = 4'd9;
    localparam logic [3:0] S_SUMRD  = 4'd10;
    localparam logic [3:0] S_SUMAC  = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0]               state_reg;
    logic [CW-1:0]            n_reg;
    logic [CW-1:0]            i_reg;
    logic [CW-1:0]            cur_reg;
    logic [CW-1:0]            j_reg;
    logic [CW-1:0]            r_reg;
    logic [CW-1:0]            best_reg;
    logic signed [POT_W-1:0]  delta_reg;
    logic signed [POT_W-1:0]  rowpot_r_reg;
    logic [AW-1:0]            base_reg;
    logic [AW-1:0]            sum_addr_reg;
    logic                     sum_zero_reg;
    logic [TOTAL_W-1:0]       total_reg;
    logic                     bad_reg;
    logic                     out_valid_reg;
    logic [TOTAL_W-1:0]       out_total_reg;
    logic                     out_bad_reg;

    logic signed [POT_W-1:0]  row_pot_reg [0:MAX_SIZE];
    logic signed [POT_W-1:0]  col_pot_reg [0:MAX_SIZE];
    logic signed [POT_W-1:0]  slack_reg   [0:MAX_SIZE];
    logic [CW-1:0]            owner_reg   [0:MAX_SIZE];
    logic [CW-1:0]            prev_reg    [0:MAX_SIZE];
    logic [MAX_SIZE:0]        in_tree_reg;

    logic [PW-1:0]            base_prod;
    logic [PW-1:0]            sum_prod;
    logic [CW-1:0]            sum_row;
    logic signed [POT_W-1:0]  red;
    logic signed [POT_W-1:0]  ns;
    logic [COST_W-1:0]        c_val;
    logic                     c_bad;
    logic [TOTAL_W-1:0]       total_sum;

    assign solving      = (state_reg != S_IDLE) && (state_reg != S_DONE);
    assign pop          = (state_reg == S_IDLE) && job_valid;
    assign result_valid = out_valid_reg;
    assign match_total  = out_total_reg;
    assign infeasible   = out_bad_reg;

    assign base_prod = PW'(r_reg - CW'(1)) * PW'(n_reg);
    assign sum_row   = owner_reg[j_reg];
    assign sum_prod  = PW'(sum_row - CW'(1)) * PW'(n_reg) + PW'(j_reg - CW'(1));

    assign red = $signed({{(POT_W-COST_W){1'b0}}, rd_data}) - rowpot_r_reg
                 - col_pot_reg[j_reg];

    always_comb
    begin
        if (red < slack_reg[j_reg])
        begin
            ns = red;
        end
        else
        begin
            ns = slack_reg[j_reg];
        end
    end

    assign c_val     = sum_zero_reg ? '0 : rd_data;
    assign c_bad     = ({2'b00, c_val} >= 16'(UNREACHABLE));
    assign total_sum = total_reg + TOTAL_W'(c_val);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = sum_addr_reg;
        if (state_reg == S_SCANRD)
        begin
            rd_en   = (j_reg <= n_reg) && !in_tree_reg[j_reg];
            rd_addr = base_reg + AW'(j_reg - CW'(1));
        end
        else if (state_reg == S_SUMRD)
        begin
            rd_en = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            i_reg         <= '0;
            cur_reg       <= '0;
            j_reg         <= '0;
            r_reg         <= '0;
            best_reg      <= '0;
            delta_reg     <= '0;
            rowpot_r_reg  <= '0;
            base_reg      <= '0;
            sum_addr_reg  <= '0;
            sum_zero_reg  <= 1'b0;
            total_reg     <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_total_reg <= '0;
            out_bad_reg   <= 1'b0;
            in_tree_reg   <= '0;
            for (int k = 0; k <= MAX_SIZE; k++)
            begin
                row_pot_reg[k] <= '0;
                col_pot_reg[k] <= '0;
                slack_reg[k]   <= '0;
                owner_reg[k]   <= '0;
                prev_reg[k]    <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        n_reg <= CW'(job.n);
                        if (job.n == '0)
                        begin
                            out_valid_reg <= 1'b1;
                            out_total_reg <= '0;
                            out_bad_reg   <= 1'b0;
                            state_reg     <= S_DONE;
                        end
                        else
                        begin
                            for (int k = 0; k <= MAX_SIZE; k++)
                            begin
                                row_pot_reg[k] <= '0;
                                col_pot_reg[k] <= '0;
                                owner_reg[k]   <= '0;
                                prev_reg[k]    <= '0;
                            end
                            i_reg     <= CW'(1);
                            state_reg <= S_PHASE;
                        end
                    end
                end
                S_PHASE:
                begin
                    owner_reg[0] <= i_reg;
                    for (int k = 0; k <= MAX_SIZE; k++)
                    begin
                        slack_reg[k] <= BIG_SLACK;
                    end
                    in_tree_reg <= '0;
                    cur_reg     <= '0;
                    state_reg   <= S_STEP;
                end
                S_STEP:
                begin
                    r_reg                 <= owner_reg[cur_reg];
                    rowpot_r_reg          <= row_pot_reg[owner_reg[cur_reg]];
                    in_tree_reg[cur_reg]  <= 1'b1;
                    delta_reg             <= BIG_SLACK;
                    best_reg              <= '0;
                    j_reg                 <= CW'(1);
                    state_reg             <= S_MUL;
                end
                S_MUL:
                begin
                    base_reg  <= base_prod[AW-1:0];
                    state_reg <= S_SCANRD;
                end
                S_SCANRD:
                begin
                    if (j_reg > n_reg)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_UPD;
                    end
                    else if (in_tree_reg[j_reg])
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                    else
                    begin
                        state_reg <= S_SCANEV;
                    end
                end
                S_SCANEV:
                begin
                    if (red < slack_reg[j_reg])
                    begin
                        slack_reg[j_reg] <= red;
                        prev_reg[j_reg]  <= cur_reg;
                    end
                    if (ns < delta_reg)
                    begin
                        delta_reg <= ns;
                        best_reg  <= j_reg;
                    end
                    j_reg     <= j_reg + CW'(1);
                    state_reg <= S_SCANRD;
                end
                S_UPD:
                begin
                    if (in_tree_reg[j_reg])
                    begin
                        row_pot_reg[owner_reg[j_reg]] <=
                            row_pot_reg[owner_reg[j_reg]] + delta_reg;
                        col_pot_reg[j_reg] <= col_pot_reg[j_reg] - delta_reg;
                    end
                    else
                    begin
                        slack_reg[j_reg] <= slack_reg[j_reg] - delta_reg;
                    end
                    if (j_reg == n_reg)
                    begin
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
                S_CHECK:
                begin
                    if (best_reg == '0)
                    begin
                        state_reg <= S_AUG;
                    end
                    else
                    begin
                        cur_reg <= best_reg;
                        if (owner_reg[best_reg] != '0)
                        begin
                            state_reg <= S_STEP;
                        end
                        else
                        begin
                            state_reg <= S_AUG;
                        end
                    end
                end
                S_AUG:
                begin
                    if (cur_reg != '0)
                    begin
                        owner_reg[cur_reg] <= owner_reg[prev_reg[cur_reg]];
                        cur_reg            <= prev_reg[cur_reg];
                    end
                    else if (i_reg == n_reg)
                    begin
                        j_reg     <= CW'(1);
                        total_reg <= '0;
                        bad_reg   <= 1'b0;
                        state_reg <= S_SUMMUL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_PHASE;
                    end
                end
                S_SUMMUL:
                begin
                    sum_addr_reg <= sum_prod[AW-1:0];
                    sum_zero_reg <= (sum_row == '0);
                    state_reg    <= S_SUMRD;
                end
                S_SUMRD:
                begin
                    state_reg <= S_SUMAC;
                end
                S_SUMAC:
                begin
                    total_reg <= total_sum;
                    bad_reg   <= bad_reg || c_bad;
                    if (j_reg == n_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_bad_reg   <= bad_reg || c_bad;
                        out_total_reg <= (bad_reg || c_bad) ? '0 : total_sum;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= S_SUMMUL;
                    end
                end
                S_DONE:
                begin
                    if (result_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/min_cost_assignment.sv =====
// Operation: n*n load words at one per cycle while cost_ready is high, then
//   the solve: n phases, each of up to n steps (memory read per column, one
//   column a cycle for the potential update), then the sum; result registered.
// Flow: one matrix at a time; the cost store's single read port and the
//   step loop set the solve time. A zero-size matrix skips the solve.
// Reset: control state clears at once; the cost store is undefined until written.
// ----------------------------------------------------------------------------
// min_cost_assignment
// Minimum-cost perfect assignment of a square cost matrix, Hungarian method.
// ----------------------------------------------------------------------------
module min_cost_assignment
    import min_asg_pkg::*;
#(
    parameter int MAX_SIZE    = 16,
    parameter int UNREACHABLE = 9999
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cost_valid,
    output logic               cost_ready,
    input  logic [SIZE_W-1:0]  size,
    input  logic [COST_W-1:0]  cost,
    input  logic               last,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [TOTAL_W-1:0] match_total,
    output logic               infeasible
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LCW   = $clog2(DEPTH + 1);

    load_gate_t        gate;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [COST_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [COST_W-1:0] rd_data;
    logic              push;
    job_t              push_job;
    logic              pop;
    job_t              head_job;
    logic              q_empty;
    logic              solving;

    assign gate.q_empty = q_empty;
    assign gate.solving = solving;

    min_asg_front #(
        .MAX_SIZE (MAX_SIZE),
        .AW       (AW),
        .LCW      (LCW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cost_valid (cost_valid),
        .cost_ready (cost_ready),
        .size       (size),
        .cost       (cost),
        .last       (last),
        .gate       (gate),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .push       (push),
        .push_job   (push_job)
    );

    min_asg_ram #(
        .WIDTH (COST_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    min_asg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    min_asg_solver #(
        .MAX_SIZE    (MAX_SIZE),
        .UNREACHABLE (UNREACHABLE),
        .AW          (AW)
    ) u_solver (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (!q_empty),
        .job          (head_job),
        .pop          (pop),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .match_total  (match_total),
        .infeasible   (infeasible),
        .solving      (solving)
    );

    a_infeasible_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && infeasible |-> match_total == '0)
        else $error("infeasible word with nonzero total");

    a_no_write_while_solving: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !solving)
        else $error("cost store written during solve");

    a_ready_needs_empty_queue: assert property (@(posedge clk) disable iff (!rst_n)
        cost_ready |-> q_empty && !solving)
        else $error("load accepted with job pending");

    a_push_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !cost_ready)
        else $error("load front open after last word");

endmodule
